/* hw/rtl/amilc_pkg.sv */
package amilc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 4096;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 16;
  localparam int RUN_W       = 16;
  localparam int THR_W       = 16;
  localparam int WIN_W       = 13;
  localparam int LIMIT_W     = THR_W + CNT_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_THRESH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_NEEDED  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_NEEDED   = CFG_IDX_W'(3);

  localparam logic [THR_W-1:0] RST_AVG_THRESH     = THR_W'(4096);
  localparam logic [WIN_W-1:0] RST_WINDOW_SAMPLES = WIN_W'(200);
  localparam logic [RUN_W-1:0] RST_MOTION_NEEDED  = RUN_W'(5);
  localparam logic [RUN_W-1:0] RST_QUIET_NEEDED   = RUN_W'(60);

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic                          buffer_end;
    logic                          ircut_on;
  } in_word_t;

  typedef struct packed {
    logic       motion_seen;
    logic       led_write;
    logic [1:0] led_level;
    logic [1:0] ir_mode_now;
  } out_word_t;

  typedef struct packed {
    logic [THR_W-1:0] avg_thresh;
    logic [WIN_W-1:0] window_samples;
    logic [RUN_W-1:0] motion_needed;
    logic [RUN_W-1:0] quiet_needed;
  } cfg_t;

  // closed window as it leaves the accumulator
  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0] count;
    logic             ircut_on;
  } window_t;

  // window with its motion limit worked out
  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_z;
    logic [LIMIT_W-1:0] limit;
    logic               ircut_on;
  } judged_t;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    logic        [DIFF_W-1:0] m;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return m[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(
    input logic [SUM_W-1:0]       s,
    input logic [SAMPLE_BITS-1:0] d
  );
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(d);
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* hw/rtl/amilc_accum.sv */
module amilc_accum
  import amilc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_word_t         word_i,
  input  logic [WIN_W-1:0] window_samples_i,
  output logic             close_o,
  output window_t          window_o
);

  logic signed [SAMPLE_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic        [SUM_W-1:0]       sum_x_q, sum_y_q, sum_z_q;
  logic        [SUM_W-1:0]       sum_x_d, sum_y_d, sum_z_d;
  logic        [CNT_W-1:0]       count_q, count_d;
  logic                          primed_q;
  logic        [CNT_W-1:0]       ws_ext;
  logic        [CNT_W-1:0]       win_lim;

  assign sum_x_d = sat_add(sum_x_q, abs_diff(word_i.accel_x, prev_x_q));
  assign sum_y_d = sat_add(sum_y_q, abs_diff(word_i.accel_y, prev_y_q));
  assign sum_z_d = sat_add(sum_z_q, abs_diff(word_i.accel_z, prev_z_q));
  assign count_d = sat_inc(count_q);

  // clamp the window to the largest supported size
  assign ws_ext  = CNT_W'(window_samples_i);
  assign win_lim = (ws_ext > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : ws_ext;

  assign close_o = primed_q && word_i.buffer_end && (count_d >= win_lim);

  assign window_o = '{sum_x:    sum_x_d,
                      sum_y:    sum_y_d,
                      sum_z:    sum_z_d,
                      count:    count_d,
                      ircut_on: word_i.ircut_on};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_z_q  <= '0;
      count_q  <= '0;
      primed_q <= 1'b0;
    end else if (fire_i) begin
      prev_x_q <= word_i.accel_x;
      prev_y_q <= word_i.accel_y;
      prev_z_q <= word_i.accel_z;
      if (!primed_q) begin
        // first buffer only loads the previous sample
        if (word_i.buffer_end) begin
          primed_q <= 1'b1;
        end
      end else if (close_o) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        count_q <= '0;
      end else begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        sum_z_q <= sum_z_d;
        count_q <= count_d;
      end
    end
  end

endmodule

/* hw/rtl/amilc_mode.sv */
module amilc_mode
  import amilc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  judged_t          judged_i,
  input  logic [RUN_W-1:0] motion_needed_i,
  input  logic [RUN_W-1:0] quiet_needed_i,
  output out_word_t        result_o
);

  logic [RUN_W-1:0] motion_run_q, motion_run_d;
  logic [RUN_W-1:0] quiet_run_q, quiet_run_d, quiet_mid;
  logic [RUN_W-1:0] motion_inc;
  logic [1:0]       mode_q, mode_d, mode_mid;
  logic [1:0]       level;
  logic             motion;
  logic             write;

  assign motion = (judged_i.sum_x > judged_i.limit) ||
                  (judged_i.sum_y > judged_i.limit) ||
                  (judged_i.sum_z > judged_i.limit);

  assign motion_inc = sat_inc(motion_run_q);

  always_comb begin
    write        = 1'b0;
    level        = MODE_OFF;
    motion_run_d = motion_run_q;
    quiet_mid    = quiet_run_q;
    mode_mid     = mode_q;
    if (motion) begin
      motion_run_d = motion_inc;
      if (motion_inc > motion_needed_i) begin
        quiet_mid = '0;
        mode_mid  = MODE_ON;
        if (mode_q != MODE_ON) begin
          write = judged_i.ircut_on;
          level = MODE_ON;
        end
      end
    end else begin
      quiet_mid    = sat_inc(quiet_run_q);
      motion_run_d = '0;
    end

    // quiet check follows every window, motion ones too
    quiet_run_d = quiet_mid;
    mode_d      = mode_mid;
    if (quiet_mid > quiet_needed_i) begin
      mode_d      = (mode_mid == MODE_PULSE) ? MODE_OFF : MODE_PULSE;
      write       = judged_i.ircut_on;
      level       = mode_d;
      quiet_run_d = '0;
    end
  end

  assign result_o = '{motion_seen: motion,
                      led_write:   write,
                      led_level:   write ? level : MODE_OFF,
                      ir_mode_now: mode_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_run_q <= '0;
      quiet_run_q  <= '0;
      mode_q       <= MODE_ON;
    end else if (step_i) begin
      motion_run_q <= motion_run_d;
      quiet_run_q  <= quiet_run_d;
      mode_q       <= mode_d;
    end
  end

  a_motion_run_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && motion |=> motion_run_q != '0)
    else $error("motion run did not advance on a motion window");

  a_motion_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !motion |=> motion_run_q == '0)
    else $error("motion run not cleared on a quiet window");

  a_no_write_filter_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !judged_i.ircut_on |-> !result_o.led_write)
    else $error("LED write issued with IR-cut filter off");

  a_mode_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(mode_q))
    else $error("IR mode changed without a window");

endmodule

/* hw/rtl/accel_motion_ir_led_control_unit.sv */
// A result is registered in stage one (accumulate), stage two (limit multiply) and
// the output register (run-counter update); output stalls hold it back.
// Throughput: one sample per cycle without output stalls; the threshold-by-count multiply has its own stage.
// Samples that close no window produce no result word.
// Reset (rst_ni, async, active low): registers to defaults, IR mode on, sums,
// counters and previous samples cleared, pipeline emptied.
module accel_motion_ir_led_control_unit
  import amilc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_fire;
  logic      close;
  window_t   window;
  logic      s1_valid_q, s2_valid_q, out_valid_q;
  window_t   s1_q;
  judged_t   s2_q;
  out_word_t out_q;
  out_word_t result;
  logic      s1_en, s2_en, out_en;
  logic      mode_step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{avg_thresh:     RST_AVG_THRESH,
                 window_samples: RST_WINDOW_SAMPLES,
                 motion_needed:  RST_MOTION_NEEDED,
                 quiet_needed:   RST_QUIET_NEEDED};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AVG_THRESH:     cfg_q.avg_thresh     <= cfg_data_i[THR_W-1:0];
        CFG_WINDOW_SAMPLES: cfg_q.window_samples <= cfg_data_i[WIN_W-1:0];
        CFG_MOTION_NEEDED:  cfg_q.motion_needed  <= cfg_data_i[RUN_W-1:0];
        CFG_QUIET_NEEDED:   cfg_q.quiet_needed   <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage loads when empty or when its word moves on
  assign out_en     = !out_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;
  assign in_fire    = in_valid_i && s1_en;
  assign mode_step  = s2_valid_q && out_en;

  amilc_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (in_fire),
    .word_i           (in_word_i),
    .window_samples_i (cfg_q.window_samples),
    .close_o          (close),
    .window_o         (window)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_fire && close;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_q <= window;
    end
    if (s2_en) begin
      s2_q.sum_x    <= s1_q.sum_x;
      s2_q.sum_y    <= s1_q.sum_y;
      s2_q.sum_z    <= s1_q.sum_z;
      s2_q.limit    <= LIMIT_W'(cfg_q.avg_thresh) * LIMIT_W'(s1_q.count);
      s2_q.ircut_on <= s1_q.ircut_on;
    end
    if (out_en) begin
      out_q <= result;
    end
  end

  amilc_mode u_mode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (mode_step),
    .judged_i        (s2_q),
    .motion_needed_i (cfg_q.motion_needed),
    .quiet_needed_i  (cfg_q.quiet_needed),
    .result_o        (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_en |=> s1_valid_q && $stable(s1_q))
    else $error("window dropped or changed while stage two was full");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_en |=> s2_valid_q && $stable(s2_q))
    else $error("judged window dropped or changed while output was full");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_en |=> s2_valid_q)
    else $error("window lost between stage one and stage two");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with the pipeline full");

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import amilc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(200);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  in_word_t in_word = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cfg_ready;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  bit jitter_en = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int dead_cycles = 0;
  int mismatch_count = 0;

  in_word_t sample_q[$];
  out_word_t window_q[$];

  // detector shadow: settings
  logic [THR_W-1:0] thr_cfg = RST_AVG_THRESH;
  logic [WIN_W-1:0] win_cfg = RST_WINDOW_SAMPLES;
  logic [RUN_W-1:0] motion_need = RST_MOTION_NEEDED;
  logic [RUN_W-1:0] quiet_need = RST_QUIET_NEEDED;

  // detector shadow: running state
  logic signed [SAMPLE_BITS-1:0] last_x = '0, last_y = '0, last_z = '0;
  logic [SUM_W-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic [CNT_W-1:0] n_samples = '0;
  logic [RUN_W-1:0] motion_streak = '0, quiet_streak = '0;
  logic [1:0] mode = MODE_ON;
  bit armed = 1'b0;

  accel_motion_ir_led_control_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [SUM_W-1:0] axis_step(input logic signed [SAMPLE_BITS-1:0] a,
                                                 input logic signed [SAMPLE_BITS-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? SUM_W'(-d) : SUM_W'(d);
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] d);
    longint t;
    t = longint'(s) + longint'(d);
    return (t > longint'(32'hFFFF_FFFF)) ? '1 : t[SUM_W-1:0];
  endfunction

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advance the shadow detector by one sample; returns 1 when a window closes.
  function automatic bit judge_sample(input in_word_t s, output out_word_t r);
    longint lim;
    int eff_win;
    bit motion;
    r = '0;
    if (!armed) begin
      last_x = s.accel_x;
      last_y = s.accel_y;
      last_z = s.accel_z;
      if (s.buffer_end) armed = 1'b1;
      return 1'b0;
    end
    acc_x = sum_sat(acc_x, axis_step(s.accel_x, last_x));
    acc_y = sum_sat(acc_y, axis_step(s.accel_y, last_y));
    acc_z = sum_sat(acc_z, axis_step(s.accel_z, last_z));
    n_samples = inc_sat(n_samples);
    last_x = s.accel_x;
    last_y = s.accel_y;
    last_z = s.accel_z;
    if (!s.buffer_end) return 1'b0;
    eff_win = (int'(win_cfg) > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg);
    if (int'(n_samples) < eff_win) return 1'b0;

    // average compare without division
    lim = longint'(thr_cfg) * longint'(n_samples);
    motion = (longint'(acc_x) > lim) || (longint'(acc_y) > lim) || (longint'(acc_z) > lim);
    if (motion) begin
      motion_streak = inc_sat(motion_streak);
      if (motion_streak > motion_need) begin
        quiet_streak = '0;
        if (mode != MODE_ON) begin
          if (s.ircut_on) begin
            r.led_write = 1'b1;
            r.led_level = MODE_ON;
          end
          mode = MODE_ON;
        end
      end
    end else begin
      quiet_streak = inc_sat(quiet_streak);
      motion_streak = '0;
    end
    // quiet check runs on motion windows too
    if (quiet_streak > quiet_need) begin
      if (s.ircut_on) begin
        r.led_write = 1'b1;
        r.led_level = (mode == MODE_PULSE) ? MODE_OFF : MODE_PULSE;
      end
      mode = (mode == MODE_PULSE) ? MODE_OFF : MODE_PULSE;
      quiet_streak = '0;
    end
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    n_samples = '0;
    r.motion_seen = motion;
    r.ir_mode_now = mode;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 50)
      $display("ERROR at %0t: %s got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                            input logic last, input logic ircut);
    in_word_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.buffer_end = last;
    s.ircut_on = ircut;
    sample_q.push_back(s);
  endtask

  task automatic settle();
    do @(posedge clk); while (sample_q.size() != 0 || in_valid || window_q.size() != 0);
    // let samples that close no window leave the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [15:0] thr;
    logic [15:0] win;
    case ($urandom_range(0, 3))
      0: thr = 16'h0000;
      1: thr = 16'hFFFF;
      default: thr = 16'($urandom_range(0, 800));
    endcase
    win = {3'($urandom), 13'($urandom_range(0, 8))};
    write_reg(CFG_AVG_THRESH, thr);
    write_reg(CFG_WINDOW_SAMPLES, win);
    write_reg(CFG_MOTION_NEEDED, 16'($urandom_range(0, 3)));
    write_reg(CFG_QUIET_NEEDED, 16'($urandom_range(0, 3)));
  endtask

  // mostly whole buffers, steady or shaking, with some loose noise
  task automatic queue_traffic(input int n_items);
    int added, len, k, j;
    bit noise, shaky;
    logic [15:0] bx, by, bz;
    logic [15:0] x, y, z;
    logic last;
    added = 0;
    while (added < n_items) begin
      len = $urandom_range(1, 6);
      noise = ($urandom_range(0, 4) == 0);
      shaky = 1'($urandom_range(0, 1));
      bx = 16'($urandom);
      by = 16'($urandom);
      bz = 16'($urandom);
      for (k = 0; k < len; k++) begin
        if (noise || shaky) begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end else begin
          j = $urandom_range(0, 31);
          x = bx + 16'(j - 16);
          j = $urandom_range(0, 31);
          y = by + 16'(j - 16);
          j = $urandom_range(0, 31);
          z = bz + 16'(j - 16);
        end
        last = noise ? 1'($urandom_range(0, 1)) : (k == len - 1);
        add_sample(x, y, z, last, 1'($urandom_range(0, 1)));
      end
      added += len;
    end
  endtask

  always @(negedge clk) begin : drive_samples
    logic v;
    in_word_t w;
    if (rst_n) begin
      v = in_valid;
      w = in_word;
      if (v && in_taken) v = 1'b0;
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0) begin
          if (jitter_en && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 11) - 1;
          end else begin
            w = sample_q.pop_front();
            v = 1'b1;
          end
        end
      end
      in_valid <= v;
      in_word <= w;
    end
  end

  always @(negedge clk) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (jitter_en) begin
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rdy = 1'b0;
      end
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin : watch_ports
    out_word_t fresh;
    out_word_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AVG_THRESH:     thr_cfg = cfg_data[THR_W-1:0];
          CFG_WINDOW_SAMPLES: win_cfg = cfg_data[WIN_W-1:0];
          CFG_MOTION_NEEDED:  motion_need = cfg_data[RUN_W-1:0];
          CFG_QUIET_NEEDED:   quiet_need = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (judge_sample(in_word, fresh)) window_q.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (window_q.size() == 0) begin
          note_mismatch("result word with nothing pending", int'(out_word), 0);
        end else begin
          want = window_q.pop_front();
          if (out_word.motion_seen !== want.motion_seen)
            note_mismatch("motion_seen", int'(out_word.motion_seen), int'(want.motion_seen));
          if (out_word.led_write !== want.led_write)
            note_mismatch("led_write", int'(out_word.led_write), int'(want.led_write));
          if (out_word.led_level !== want.led_level)
            note_mismatch("led_level", int'(out_word.led_level), int'(want.led_level));
          if (out_word.ir_mode_now !== want.ir_mode_now)
            note_mismatch("ir_mode_now", int'(out_word.ir_mode_now), int'(want.ir_mode_now));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready) &&
        !(cfg_valid && cfg_ready))
      dead_cycles++;
    else
      dead_cycles = 0;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // priming buffer, then a short buffer end under the default window
    add_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b0, 1'b1);
    add_sample(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0);
    add_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    settle();

    // zero window judges at every buffer end; unused index must change nothing
    write_reg(CFG_AVG_THRESH, 16'd0);
    write_reg(CFG_WINDOW_SAMPLES, 16'd0);
    write_reg(CFG_MOTION_NEEDED, 16'd0);
    write_reg(CFG_QUIET_NEEDED, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    settle();

    // full-scale step sits exactly on the top threshold: still quiet
    write_reg(CFG_AVG_THRESH, 16'hFFFF);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    settle();
    write_reg(CFG_AVG_THRESH, 16'hFFFE);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    settle();

    write_reg(CFG_AVG_THRESH, 16'd100);
    write_reg(CFG_WINDOW_SAMPLES, 16'd3);
    write_reg(CFG_MOTION_NEEDED, 16'd2);
    write_reg(CFG_QUIET_NEEDED, 16'd1);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    for (k = 0; k < 8; k++)
      add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, k % 3 == 1, 1'b1);
    settle();

    // lowered quiet limit trips on a motion window
    write_reg(CFG_QUIET_NEEDED, 16'd0);
    for (k = 0; k < 3; k++)
      add_sample((k == 1) ? 16'h7FFF : 16'h8000, 16'h7FFF, 16'h7FFF, k == 2, 1'b1);
    settle();
    write_reg(CFG_MOTION_NEEDED, 16'd0);
    for (k = 0; k < 3; k++)
      add_sample((k == 1) ? 16'h8000 : 16'h7FFF, 16'h7FFF, 16'h7FFF, k == 2, 1'b0);
    settle();

    // oversized window holds the count below its clamp, so buffer ends only accumulate
    write_reg(CFG_WINDOW_SAMPLES, 16'hFFFF);
    for (k = 0; k < 4; k++)
      add_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b1);
    settle();

    for (k = 0; k < 4; k++) begin
      pick_settings();
      queue_traffic(115);
      settle();
    end
    jitter_en = 1'b0;
    pick_settings();
    queue_traffic(115);
    settle();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
